// ===== hdl/multichannel_pwm_with_output_map_core_defines.svh =====
// ----------------------------------------------------------------------------
// multichannel pwm assertion macros
// shared property shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PWM_WITH_OUTPUT_MAP_CORE_DEFINES_SVH
`define MULTICHANNEL_PWM_WITH_OUTPUT_MAP_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define MPWM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpwm property violated");

// consequent checked in the next cycle
`define MPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpwm property violated");

`endif

// ===== hdl/mpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwm_pkg
// shared constants and types of the multichannel pwm controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpwm_pkg;

    // default configuration
    localparam int NUM_OUTPUTS_DEF  = 24;
    localparam int COUNTER_BITS_DEF = 13;
    localparam int SELECT_BITS_DEF  = 5;

    // bus field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 32;
    localparam int WORD_W    = ADDR_W - 2;
    localparam int S_TDATA_W = ADDR_W + DATA_W;

    // register words (byte offset >> 2)
    localparam logic [WORD_W-1:0] GCTL_WORD = 6'h00;
    localparam logic [WORD_W-1:0] MAP_WORD  = 6'h10;
    localparam logic [WORD_W-1:0] CMP_WORD  = 6'h20;

    // map word layout
    localparam int FIELDS_PER_WORD = 4;
    localparam int FIELD_STRIDE    = 8;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

endpackage

// ===== hdl/mpwm_regs.sv =====
// ----------------------------------------------------------------------------
// mpwm_regs
// register file, period counter and read mux, with the first pipeline stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_pwm_with_output_map_core_defines.svh"

module mpwm_regs #(
    parameter int NUM_OUTPUTS  = mpwm_pkg::NUM_OUTPUTS_DEF,
    parameter int COUNTER_BITS = mpwm_pkg::COUNTER_BITS_DEF,
    parameter int SELECT_BITS  = mpwm_pkg::SELECT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mpwm_pkg::op_t                       operation,
    input  logic [mpwm_pkg::ADDR_W-1:0]         address,
    input  logic [mpwm_pkg::DATA_W-1:0]         write_data,
    output logic                                stage_valid,
    input  logic                                stage_ready,
    output logic [mpwm_pkg::DATA_W-1:0]         stage_read_data,
    output logic                                enable,
    output logic [COUNTER_BITS-1:0]             counter,
    output logic [NUM_OUTPUTS*COUNTER_BITS-1:0] compare_flat,
    output logic [NUM_OUTPUTS*SELECT_BITS-1:0]  map_flat
);
    import mpwm_pkg::*;

    logic                    enable_reg;
    logic                    enable_next;
    logic [COUNTER_BITS-1:0] counter_reg;
    logic [COUNTER_BITS-1:0] counter_next;
    logic [COUNTER_BITS-1:0] cmp_reg  [NUM_OUTPUTS];
    logic [COUNTER_BITS-1:0] cmp_next [NUM_OUTPUTS];
    logic [SELECT_BITS-1:0]  map_reg  [NUM_OUTPUTS];
    logic [SELECT_BITS-1:0]  map_next [NUM_OUTPUTS];
    logic                    stage_valid_reg;
    logic [DATA_W-1:0]       stage_rd_reg;
    logic [DATA_W-1:0]       stage_rd_next;
    logic [DATA_W-1:0]       read_mux;
    logic [COUNTER_BITS-1:0] cmp_wr;
    logic [WORD_W-1:0]       word;
    logic                    accept;

    assign word     = address[ADDR_W-1:2];
    assign in_ready = !stage_valid_reg || stage_ready;
    assign accept   = in_valid && in_ready;

    // saturate compare writes to the counter range
    assign cmp_wr = (|write_data[DATA_W-1:COUNTER_BITS]) ? '1 : write_data[COUNTER_BITS-1:0];

    always_comb
    begin
        read_mux = '0;
        if (word == GCTL_WORD)
        begin
            read_mux = DATA_W'(enable_reg);
        end
        for (int o = 0; o < NUM_OUTPUTS; o++)
        begin
            if (word == MAP_WORD + WORD_W'(o / FIELDS_PER_WORD))
            begin
                read_mux[FIELD_STRIDE*(o % FIELDS_PER_WORD) +: SELECT_BITS] = map_reg[o];
            end
        end
        for (int c = 0; c < NUM_OUTPUTS; c++)
        begin
            if (word == CMP_WORD + WORD_W'(c))
            begin
                read_mux = DATA_W'(cmp_reg[c]);
            end
        end
    end

    always_comb
    begin
        enable_next   = enable_reg;
        counter_next  = counter_reg;
        cmp_next      = cmp_reg;
        map_next      = map_reg;
        stage_rd_next = '0;
        if (accept)
        begin
            unique case (operation)
                OP_READ:
                begin
                    stage_rd_next = read_mux;
                end
                OP_WRITE:
                begin
                    if (word == GCTL_WORD)
                    begin
                        enable_next = write_data[0];
                        if (!write_data[0])
                        begin
                            counter_next = '0;
                        end
                    end
                    for (int o = 0; o < NUM_OUTPUTS; o++)
                    begin
                        if (word == MAP_WORD + WORD_W'(o / FIELDS_PER_WORD))
                        begin
                            map_next[o] =
                                write_data[FIELD_STRIDE*(o % FIELDS_PER_WORD) +: SELECT_BITS];
                        end
                    end
                    for (int c = 0; c < NUM_OUTPUTS; c++)
                    begin
                        if (word == CMP_WORD + WORD_W'(c))
                        begin
                            cmp_next[c] = cmp_wr;
                        end
                    end
                end
                OP_TICK:
                begin
                    counter_next = enable_reg ? counter_reg + COUNTER_BITS'(1) : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            counter_reg     <= '0;
            cmp_reg         <= '{default: '0};
            map_reg         <= '{default: '0};
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg  <= enable_next;
            counter_reg <= counter_next;
            cmp_reg     <= cmp_next;
            map_reg     <= map_next;
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_rd_reg <= stage_rd_next;
        end
    end

    for (genvar g = 0; g < NUM_OUTPUTS; g++)
    begin : g_flat
        assign compare_flat[g*COUNTER_BITS +: COUNTER_BITS] = cmp_reg[g];
        assign map_flat[g*SELECT_BITS +: SELECT_BITS]       = map_reg[g];
    end

    assign stage_valid     = stage_valid_reg;
    assign stage_read_data = stage_rd_reg;
    assign enable          = enable_reg;
    assign counter         = counter_reg;

    // counter stays parked at zero while disabled
    `MPWM_ASSERT_SAME(a_cnt_idle, !enable_reg, counter_reg == '0)
    // a stalled stage keeps its word
    `MPWM_ASSERT_NEXT(a_stage_hold, stage_valid_reg && !stage_ready,
        stage_valid_reg && $stable(stage_rd_reg))
    // only reads return data
    `MPWM_ASSERT_NEXT(a_rd_zero, accept && operation != OP_READ, stage_rd_reg == '0)

endmodule

// ===== hdl/mpwm_eval.sv =====
// ----------------------------------------------------------------------------
// mpwm_eval
// per-output compare through the channel map, with the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_pwm_with_output_map_core_defines.svh"

module mpwm_eval #(
    parameter int NUM_OUTPUTS  = mpwm_pkg::NUM_OUTPUTS_DEF,
    parameter int COUNTER_BITS = mpwm_pkg::COUNTER_BITS_DEF,
    parameter int SELECT_BITS  = mpwm_pkg::SELECT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                stage_valid,
    output logic                                stage_ready,
    input  logic [mpwm_pkg::DATA_W-1:0]         stage_read_data,
    input  logic                                enable,
    input  logic [COUNTER_BITS-1:0]             counter,
    input  logic [NUM_OUTPUTS*COUNTER_BITS-1:0] compare_flat,
    input  logic [NUM_OUTPUTS*SELECT_BITS-1:0]  map_flat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mpwm_pkg::DATA_W-1:0]         read_data,
    output logic [NUM_OUTPUTS-1:0]              pwm_lines
);
    import mpwm_pkg::*;

    localparam int SEL_SPAN = 1 << SELECT_BITS;

    logic [NUM_OUTPUTS-1:0] hit;
    logic [SEL_SPAN-1:0]    hit_span;
    logic [NUM_OUTPUTS-1:0] lines_next;
    logic [NUM_OUTPUTS-1:0] lines_reg;
    logic [DATA_W-1:0]      rd_reg;
    logic                   out_valid_reg;

    // one comparator per channel
    for (genvar c = 0; c < NUM_OUTPUTS; c++)
    begin : g_hit
        assign hit[c] = counter < compare_flat[c*COUNTER_BITS +: COUNTER_BITS];
    end

    // selectors past the last channel see a low line
    for (genvar k = 0; k < SEL_SPAN; k++)
    begin : g_span
        if (k < NUM_OUTPUTS)
        begin : g_live
            assign hit_span[k] = hit[k];
        end
        else
        begin : g_dead
            assign hit_span[k] = 1'b0;
        end
    end

    for (genvar i = 0; i < NUM_OUTPUTS; i++)
    begin : g_line
        assign lines_next[i] = enable && hit_span[map_flat[i*SELECT_BITS +: SELECT_BITS]];
    end

    assign stage_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid && stage_ready)
        begin
            rd_reg    <= stage_read_data;
            lines_reg <= lines_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = rd_reg;
    assign pwm_lines = lines_reg;

    // disabled block drives every line low
    `MPWM_ASSERT_NEXT(a_off_low, stage_valid && stage_ready && !enable, lines_reg == '0)
    // a moved word shows up at the output
    `MPWM_ASSERT_NEXT(a_move_valid, stage_valid && stage_ready, out_valid_reg)
    // a held result blocks the stage behind it
    `MPWM_ASSERT_SAME(a_hold_block, out_valid_reg && !out_ready, !stage_ready)

endmodule

// ===== hdl/multichannel_pwm_with_output_map_core.sv =====
// an accepted word passes the stage register, then the result register, to the master side
// throughput: one word per cycle while the master side takes words, reads, writes and ticks alike, no stall of its own
// the register file updates at the accept edge, the line compare runs in the next stage
// reset: asynchronous, active low; enable, counter, compares and map clear to zero
// after reset both stages are empty and the slave side is ready at once
// ----------------------------------------------------------------------------
// multichannel_pwm_with_output_map_core
// mapped multichannel pwm controller behind a word-wide register stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_pwm_with_output_map_core #(
    parameter int  NUM_OUTPUTS  = mpwm_pkg::NUM_OUTPUTS_DEF,
    parameter int  COUNTER_BITS = mpwm_pkg::COUNTER_BITS_DEF,
    parameter int  SELECT_BITS  = mpwm_pkg::SELECT_BITS_DEF,
    localparam int M_TDATA_W    = ((mpwm_pkg::DATA_W + NUM_OUTPUTS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mpwm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // address, write_data
    input  logic [mpwm_pkg::OP_W-1:0]      s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [M_TDATA_W-1:0]           m_axis_tdata   // read_data, pwm_lines, zero pad
);
    import mpwm_pkg::*;

    // slave word split into its fields
    op_t                          operation;
    logic [ADDR_W-1:0]            address;
    logic [DATA_W-1:0]            write_data;

    // stage between register file and line compare
    logic                         stage_valid;
    logic                         stage_ready;
    logic [DATA_W-1:0]            stage_read_data;

    // live state seen by the line compare
    logic                         enable;
    logic [COUNTER_BITS-1:0]      counter;
    logic [NUM_OUTPUTS*COUNTER_BITS-1:0] compare_flat;
    logic [NUM_OUTPUTS*SELECT_BITS-1:0]  map_flat;

    // result fields
    logic [DATA_W-1:0]            read_data;
    logic [NUM_OUTPUTS-1:0]       pwm_lines;

    assign operation  = op_t'(s_axis_tuser);
    assign address    = s_axis_tdata[ADDR_W-1:0];
    assign write_data = s_axis_tdata[ADDR_W +: DATA_W];

    // register file: decode, write, saturate, tick and read back
    mpwm_regs #(
        .NUM_OUTPUTS  (NUM_OUTPUTS),
        .COUNTER_BITS (COUNTER_BITS),
        .SELECT_BITS  (SELECT_BITS)
    ) u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .operation       (operation),
        .address         (address),
        .write_data      (write_data),
        .stage_valid     (stage_valid),
        .stage_ready     (stage_ready),
        .stage_read_data (stage_read_data),
        .enable          (enable),
        .counter         (counter),
        .compare_flat    (compare_flat),
        .map_flat        (map_flat)
    );

    // line compare sees the state left by the staged word, since nothing new
    // is accepted while that word is held
    mpwm_eval #(
        .NUM_OUTPUTS  (NUM_OUTPUTS),
        .COUNTER_BITS (COUNTER_BITS),
        .SELECT_BITS  (SELECT_BITS)
    ) u_eval (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage_valid     (stage_valid),
        .stage_ready     (stage_ready),
        .stage_read_data (stage_read_data),
        .enable          (enable),
        .counter         (counter),
        .compare_flat    (compare_flat),
        .map_flat        (map_flat),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .read_data       (read_data),
        .pwm_lines       (pwm_lines)
    );

    // pack result, pad bits above the lines are zero
    assign m_axis_tdata = M_TDATA_W'({pwm_lines, read_data});

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives register reads, writes and counter ticks into the pwm core and
// compares every master-side word with a cycle-free model of the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import mpwm_pkg::*;

    localparam int N_OUT    = NUM_OUTPUTS_DEF;
    localparam int CNT_W    = COUNTER_BITS_DEF;
    localparam int SEL_W    = SELECT_BITS_DEF;
    localparam int M_W      = ((DATA_W + N_OUT + 7) / 8) * 8;
    localparam int MAP_CNT  = (N_OUT + 3) / 4;
    localparam int CNT_TOP  = (1 << CNT_W) - 1;
    localparam int CYCLE_LIMIT = 30000;

    // register byte offsets
    localparam logic [ADDR_W-1:0] GCTL_BASE = {GCTL_WORD, 2'b00};
    localparam logic [ADDR_W-1:0] MAP_BASE  = {MAP_WORD, 2'b00};
    localparam logic [ADDR_W-1:0] CMP_BASE  = {CMP_WORD, 2'b00};

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic [N_OUT-1:0]  lines;
    } pwm_result_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [DATA_W-1:0] rd;
        logic [N_OUT-1:0]  lines;
    } reg_access_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]     s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_W-1:0]      m_axis_tdata;

    // model state
    logic              pwm_enable;
    logic [CNT_W-1:0]  pwm_count;
    logic [CNT_W-1:0]  duty_cmp [N_OUT];
    logic [SEL_W-1:0]  line_sel [N_OUT];

    pwm_result_t pending_results [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 35;
    int          sink_idle_pct = 75;

    reg_access_t opening_rows [0:25];

    multichannel_pwm_with_output_map_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // address, write_data
        .s_axis_tuser  (s_axis_tuser),   // operation
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // read_data, pwm_lines, zero pad
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the register file and the line compare
    // ------------------------------------------------------------------------

    function automatic logic [DATA_W-1:0] reg_readback(logic [ADDR_W-1:0] a);
        int                ai;
        int                w;
        logic [DATA_W-1:0] v;
        ai = int'(a);
        v  = '0;
        if (a == GCTL_BASE)
        begin
            v[0] = pwm_enable;
        end
        else if (ai >= MAP_BASE && ai < MAP_BASE + 4 * MAP_CNT)
        begin
            w = (ai - MAP_BASE) >> 2;
            for (int f = 0; f < 4; f++)
            begin
                if (4 * w + f < N_OUT)
                    v[8*f +: SEL_W] = line_sel[4*w + f];
            end
        end
        else if (ai >= CMP_BASE && ai < CMP_BASE + 4 * N_OUT)
        begin
            v[CNT_W-1:0] = duty_cmp[(ai - CMP_BASE) >> 2];
        end
        return v;
    endfunction

    task automatic reg_update(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        int ai;
        int w;
        ai = int'(a);
        if (a == GCTL_BASE)
        begin
            pwm_enable = d[0];
            // clearing the enable also restarts the period
            if (!d[0])
                pwm_count = '0;
        end
        else if (ai >= MAP_BASE && ai < MAP_BASE + 4 * MAP_CNT)
        begin
            w = (ai - MAP_BASE) >> 2;
            for (int f = 0; f < 4; f++)
            begin
                if (4 * w + f < N_OUT)
                    line_sel[4*w + f] = d[8*f +: SEL_W];
            end
        end
        else if (ai >= CMP_BASE && ai < CMP_BASE + 4 * N_OUT)
        begin
            // oversized compare values clip to the top count
            duty_cmp[(ai - CMP_BASE) >> 2] = (d > CNT_TOP) ? CNT_TOP[CNT_W-1:0] : d[CNT_W-1:0];
        end
    endtask

    function automatic logic [N_OUT-1:0] line_levels();
        logic [N_OUT-1:0] v;
        v = '0;
        if (pwm_enable)
        begin
            for (int i = 0; i < N_OUT; i++)
            begin
                // selectors past the last channel hold the line low
                if (int'(line_sel[i]) < N_OUT && pwm_count < duty_cmp[line_sel[i]])
                    v[i] = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic pwm_predict(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                               output pwm_result_t res);
        logic [ADDR_W-1:0] a;
        a      = addr & 8'hFC;
        res.rd = '0;
        case (op)
            OP_READ:  res.rd = reg_readback(a);
            OP_WRITE: reg_update(a, data);
            OP_TICK:  pwm_count = pwm_enable ? pwm_count + 1'b1 : '0;
            default:  ;
        endcase
        // lines reflect the counter after this word
        res.lines = line_levels();
    endtask

    // ------------------------------------------------------------------------
    // slave-side driver: inputs change on the falling edge
    // ------------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after the accept
    task automatic issue_word(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                              logic typed, pwm_result_t typed_res);
        pwm_result_t res;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pwm_predict(op, addr, data, res);
        pending_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic issue_modeled(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        issue_word(op, addr, data, 1'b0, '0);
    endtask

    // random word, weighted toward valid registers and ticks
    task automatic random_word();
        int                pick;
        int                ch;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(0, 99);
        op   = OP_WRITE;
        addr = '0;
        data = $urandom;
        if (pick < 45)
        begin
            op = OP_TICK;
            addr = ADDR_W'($urandom_range(0, 255));
        end
        else if (pick < 60)
        begin
            ch   = $urandom_range(0, N_OUT - 1);
            addr = ADDR_W'(CMP_BASE + 4 * ch + $urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: data = $urandom_range(0, 300);
                1: data = $urandom_range(CNT_TOP - 10, CNT_TOP + 10);
                default: data = $urandom;
            endcase
        end
        else if (pick < 70)
        begin
            addr = ADDR_W'(MAP_BASE + 4 * $urandom_range(0, MAP_CNT - 1) +
                           $urandom_range(0, 3));
            for (int f = 0; f < 4; f++)
            begin
                // mostly valid channels, now and then a selector past the last channel
                data[8*f +: 8] = {3'($urandom), ($urandom_range(0, 9) == 0) ?
                                  5'($urandom_range(N_OUT, 31)) :
                                  5'($urandom_range(0, N_OUT - 1))};
            end
        end
        else if (pick < 75)
        begin
            addr    = ADDR_W'(GCTL_BASE + $urandom_range(0, 3));
            data[0] = ($urandom_range(0, 4) != 0);
        end
        else if (pick < 90)
        begin
            op = OP_READ;
            case ($urandom_range(0, 2))
                0: addr = ADDR_W'(GCTL_BASE + $urandom_range(0, 3));
                1: addr = ADDR_W'(MAP_BASE + $urandom_range(0, 4 * MAP_CNT - 1));
                default: addr = ADDR_W'(CMP_BASE + $urandom_range(0, 4 * N_OUT - 1));
            endcase
        end
        else if (pick < 97)
        begin
            // noise anywhere in the address space
            op   = op_t'($urandom_range(0, 3));
            addr = ADDR_W'($urandom_range(0, 255));
        end
        else
        begin
            op   = OP_NONE;
            addr = ADDR_W'($urandom_range(0, 255));
        end
        issue_modeled(op, addr, data);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // master side: ready changes on the falling edge, words checked on the rising
    // ------------------------------------------------------------------------

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        pwm_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected word on master side: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== exp_res.rd)
                begin
                    $error("read_data mismatch: expected %h, got %h",
                           exp_res.rd, m_axis_tdata[DATA_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[DATA_W +: N_OUT] !== exp_res.lines)
                begin
                    $error("pwm_lines mismatch: expected %h, got %h",
                           exp_res.lines, m_axis_tdata[DATA_W +: N_OUT]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        // opening words: rows with typed results are read straight off the register map
        opening_rows = '{
            '{OP_READ,  8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000, 24'h0},   // reset enable
            '{OP_READ,  8'h80, 32'h0000_0000, 1'b1, 32'h0000_0000, 24'h0},   // reset compare
            '{OP_READ,  8'hFC, 32'h0000_0000, 1'b1, 32'h0000_0000, 24'h0},   // unmapped read
            '{OP_WRITE, 8'h80, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 24'h0},   // saturating write
            '{OP_READ,  8'h80, 32'h0000_0000, 1'b1, 32'h0000_1FFF, 24'h0},
            '{OP_WRITE, 8'h87, 32'h0000_2000, 1'b1, 32'h0000_0000, 24'h0},   // unaligned, just over
            '{OP_READ,  8'h85, 32'h0000_0000, 1'b1, 32'h0000_1FFF, 24'h0},
            '{OP_WRITE, 8'h88, 32'h0000_1FFF, 1'b1, 32'h0000_0000, 24'h0},   // top count exactly
            '{OP_WRITE, 8'h40, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 24'h0},   // selectors off range
            '{OP_READ,  8'h40, 32'h0000_0000, 1'b1, 32'h1F1F_1F1F, 24'h0},
            '{OP_WRITE, 8'h54, 32'h1701_0200, 1'b1, 32'h0000_0000, 24'h0},   // last map word
            '{OP_READ,  8'h54, 32'h0000_0000, 1'b1, 32'h1701_0200, 24'h0},
            '{OP_WRITE, 8'h58, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 24'h0},   // past the map
            '{OP_READ,  8'h58, 32'h0000_0000, 1'b1, 32'h0000_0000, 24'h0},
            '{OP_WRITE, 8'hDC, 32'h0000_0005, 1'b1, 32'h0000_0000, 24'h0},   // last compare
            '{OP_READ,  8'hDC, 32'h0000_0000, 1'b1, 32'h0000_0005, 24'h0},
            '{OP_WRITE, 8'hE0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 24'h0},   // past compares
            '{OP_TICK,  8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000, 24'h0},   // disabled tick
            '{OP_WRITE, 8'h00, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 24'h0},   // enable
            '{OP_TICK,  8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 24'h0},
            '{OP_TICK,  8'h00, 32'h0000_0000, 1'b0, 32'h0000_0000, 24'h0},
            '{OP_NONE,  8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 24'h0},   // no-op word
            '{OP_READ,  8'h03, 32'h0000_0000, 1'b0, 32'h0000_0000, 24'h0},
            '{OP_WRITE, 8'h00, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 24'h0},   // disable clears
            '{OP_READ,  8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000, 24'h0},
            '{OP_WRITE, 8'h00, 32'h0000_0001, 1'b0, 32'h0000_0000, 24'h0}
        };

        pwm_enable = 1'b0;
        pwm_count  = '0;
        for (int i = 0; i < N_OUT; i++)
        begin
            duty_cmp[i] = '0;
            line_sel[i] = '0;
        end

        // reset held low, then released on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_rows[k])
            issue_word(opening_rows[k].op, opening_rows[k].addr, opening_rows[k].data,
                       opening_rows[k].typed, {opening_rows[k].rd, opening_rows[k].lines});

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 35;
                    sink_idle_pct = 75;
                end
                1:
                begin
                    src_idle_pct  = 75;
                    sink_idle_pct = 35;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            // sender holds off until the pipe has drained
            s_axis_tvalid <= 1'b0;
            wait_drained();

            for (int n = 0; n < 140; n++)
                random_word();

            if (phase == 2)
            begin
                // short run: lines 0-3 on channel 0, high only for the first counts
                issue_modeled(OP_WRITE, CMP_BASE, 32'h0000_0008);
                issue_modeled(OP_WRITE, MAP_BASE, 32'h0000_0000);
                issue_modeled(OP_WRITE, GCTL_BASE, 32'h0000_0000);
                issue_modeled(OP_WRITE, GCTL_BASE, 32'h0000_0001);
                for (int n = 0; n < 16; n++)
                    issue_modeled(OP_TICK, 8'h00, 32'h0000_0000);
            end
        end

        s_axis_tvalid <= 1'b0;
        sink_idle_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // two-stage pipe: wait on for any stray word
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mpwm_pkg.sv
hdl/mpwm_regs.sv
hdl/mpwm_eval.sv
hdl/multichannel_pwm_with_output_map_core.sv
tb/tb_top.sv
